>>> rtl/bmo_pkg.sv
// ----------------------------------------------------------------------------
// bmo_pkg
// Shared types, constants and elaboration-time tables of the bicycle model
// odometry unit.
// ----------------------------------------------------------------------------
package bmo_pkg;

    localparam int POS_WIDTH_DEF    = 32;
    localparam int CORDIC_STEPS_DEF = 16;

    // cordic datapath
    localparam int TAB_LEN = 24;
    localparam int STEP_W  = 5;
    localparam int XW      = 34;
    localparam int AW      = 33;

    // bit-serial multiplier
    localparam int MW      = 56;
    localparam int MB      = 22;
    localparam int MCNT_W  = 5;

    // stream widths
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 112;
    localparam int EL_W        = 21;

    // heading arithmetic
    localparam int HD_W = 18;
    localparam logic signed [HD_W-1:0] WRAP_LIMIT = 18'sd25722;
    localparam logic signed [HD_W-1:0] WRAP_STEP  = 18'sd51446;
    localparam logic signed [HD_W-1:0] HD_MAX     = 18'sd32767;
    localparam logic signed [HD_W-1:0] HD_MIN     = -18'sd32768;

    localparam logic [EL_W-1:0] EL_MIN = 21'd1049;
    localparam logic [EL_W-1:0] EL_MAX = 21'd1048576;

    // register map
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_START_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_YAW = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BICYCLE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLIP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_REAR  = 3'd5;

    localparam logic signed [31:0] START_X_RST   = 32'sd163840;
    localparam logic signed [31:0] START_Y_RST   = 32'sd32768;
    localparam logic signed [15:0] START_YAW_RST = 16'sd0;
    localparam logic               BICYCLE_RST   = 1'b0;
    localparam logic [15:0]        SLIP_RST      = 16'd7562;
    localparam logic [15:0]        INV_REAR_RST  = 16'd8533;

    typedef logic signed [AW-1:0] angle_t;
    typedef logic signed [XW-1:0] vec_t;
    typedef angle_t atan_tab_t [TAB_LEN];

    typedef struct packed {
        logic start;
        logic vector;
    } cordic_req_t;

    typedef struct packed {
        logic done;
    } cordic_rsp_t;

    // pi at 2^-28 rad
    localparam angle_t PI_Q    = AW'($rtoi(3.14159265358979323846 * (2.0 ** 28) + 0.5));
    localparam angle_t NEG_PI  = -PI_Q;
    localparam angle_t PI_HALF = PI_Q >>> 1;
    localparam angle_t NEG_PI_HALF = -PI_HALF;
    localparam angle_t TWO_PI  = PI_Q <<< 1;

    function automatic atan_tab_t make_atan_tab();
        atan_tab_t t;
        real       r;
        for (int i = 0; i < TAB_LEN; i++)
        begin
            r    = $atan(2.0 ** (-i)) * (2.0 ** 28);
            t[i] = AW'($rtoi(r + 0.5));
        end
        return t;
    endfunction

    // reciprocal of the rotation gain at 2^-30
    function automatic vec_t cordic_gain(input int steps);
        real p;
        real a;
        p = 1.0;
        for (int i = 0; i < steps && i < TAB_LEN; i++)
        begin
            p = p * (1.0 + 2.0 ** (-2 * i));
        end
        a = $floor($sqrt(p) * (2.0 ** 30));
        return XW'($rtoi($floor((2.0 ** 60) * (a ** (-1.0)) + 0.5)));
    endfunction

endpackage

>>> rtl/bmo_cordic.sv
// ----------------------------------------------------------------------------
// bmo_cordic
// Shared iterative cordic: rotation (sine/cosine with range folding) or
// vectoring (angle of a vector), one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module bmo_cordic
    import bmo_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cordic_req_t req,
    input  vec_t        x_in,
    input  vec_t        y_in,
    input  angle_t      z_in,
    output cordic_rsp_t rsp,
    output vec_t        x_out,
    output vec_t        y_out,
    output angle_t      z_out
);

    localparam atan_tab_t ATAN_TAB = make_atan_tab();
    localparam vec_t GAIN = cordic_gain(CORDIC_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_WRAP = 4'b0010,
        C_FLIP = 4'b0100,
        C_ITER = 4'b1000
    } cstate_t;

    cstate_t           state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              vec_reg, vec_next;
    logic              flip_reg, flip_next;
    logic              done_reg, done_next;
    vec_t              x_reg, x_next;
    vec_t              y_reg, y_next;
    angle_t            z_reg, z_next;

    vec_t   xs;
    vec_t   ys;
    vec_t   xi;
    vec_t   yi;
    logic   dir;

    always_comb
    begin
        xs  = x_reg >>> step_reg;
        ys  = y_reg >>> step_reg;
        dir = vec_reg ? y_reg[XW-1] : ~z_reg[AW-1];
        xi  = dir ? (x_reg - ys) : (x_reg + ys);
        yi  = dir ? (y_reg + xs) : (y_reg - xs);

        state_next = state_reg;
        step_next  = step_reg;
        vec_next   = vec_reg;
        flip_next  = flip_reg;
        done_next  = 1'b0;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;

        case (state_reg)
            C_IDLE:
            begin
                if (req.start)
                begin
                    vec_next  = req.vector;
                    flip_next = 1'b0;
                    step_next = '0;
                    if (req.vector)
                    begin
                        x_next     = x_in;
                        y_next     = y_in;
                        z_next     = '0;
                        state_next = C_ITER;
                    end
                    else
                    begin
                        x_next     = GAIN;
                        y_next     = '0;
                        z_next     = z_in;
                        state_next = C_WRAP;
                    end
                end
            end
            C_WRAP:
            begin
                if (z_reg > PI_Q)
                begin
                    z_next = z_reg - TWO_PI;
                end
                else if (z_reg < NEG_PI)
                begin
                    z_next = z_reg + TWO_PI;
                end
                state_next = C_FLIP;
            end
            C_FLIP:
            begin
                // fold into the right half plane, negate both results at the end
                if (z_reg > PI_HALF)
                begin
                    z_next    = z_reg - PI_Q;
                    flip_next = 1'b1;
                end
                else if (z_reg < NEG_PI_HALF)
                begin
                    z_next    = z_reg + PI_Q;
                    flip_next = 1'b1;
                end
                state_next = C_ITER;
            end
            C_ITER:
            begin
                z_next    = dir ? (z_reg - ATAN_TAB[step_reg]) : (z_reg + ATAN_TAB[step_reg]);
                x_next    = xi;
                y_next    = yi;
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    if (flip_reg)
                    begin
                        x_next = -xi;
                        y_next = -yi;
                    end
                    done_next  = 1'b1;
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            step_reg  <= '0;
            vec_reg   <= 1'b0;
            flip_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            vec_reg   <= vec_next;
            flip_reg  <= flip_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign rsp.done = done_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;

endmodule

>>> rtl/bicycle_model_odometry_unit.sv
// ----------------------------------------------------------------------------
// bicycle_model_odometry_unit
// Kinematic bicycle model dead reckoning, one odometry tick per request.
// ----------------------------------------------------------------------------
// A tick whose elapsed time lies outside 1 ms to 1 s only updates the heading
// and gives no result. For any other tick, seven products go through one
// bit-serial multiplier at one multiplier bit per cycle, and up to four angle
// evaluations share one cordic at one micro-rotation per cycle (the vectoring
// step is skipped when the slip vector is zero), before the result is loaded
// into the output register. A new tick is taken once the result sits in the
// output register, while that result still waits.
// ----------------------------------------------------------------------------
module bicycle_model_odometry_unit
    import bmo_pkg::*;
#(
    parameter int POS_WIDTH    = POS_WIDTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // speed, steering_angle, imu_yaw, elapsed, zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // yaw_valid
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // pos_x, pos_y, heading, speed_out, yaw_rate
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]            cfg_data
);

    localparam int CW = ((POS_WIDTH > 32) ? POS_WIDTH : 32) + 2;
    localparam logic signed [CW-1:0] PMAX = {{(CW-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}};
    localparam logic signed [CW-1:0] PMIN = ~PMAX;
    localparam logic signed [CW-1:0] I32MAX = {{(CW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [CW-1:0] I32MIN = ~I32MAX;
    localparam logic signed [MW-1:0] RND_POS = MW'(2 ** 29);
    localparam logic signed [MW-1:0] RND_YR  = MW'(2 ** 23);
    localparam logic signed [MW-1:0] YR_MAX  = MW'(32767);
    localparam logic signed [MW-1:0] YR_MIN  = ~YR_MAX;
    localparam logic [MCNT_W-1:0] MB_LAST = MCNT_W'(MB - 1);
    localparam logic [MCNT_W-1:0] MB_DONE = MCNT_W'(MB);
    localparam logic signed [POS_WIDTH-1:0] POS_X_RST = POS_WIDTH'(START_X_RST);
    localparam logic signed [POS_WIDTH-1:0] POS_Y_RST = POS_WIDTH'(START_Y_RST);

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_SC1  = 13'b0000000000010,
        S_MN   = 13'b0000000000100,
        S_VEC  = 13'b0000000001000,
        S_SC2  = 13'b0000000010000,
        S_MXA  = 13'b0000000100000,
        S_MXB  = 13'b0000001000000,
        S_MYA  = 13'b0000010000000,
        S_MYB  = 13'b0000100000000,
        S_SC3  = 13'b0001000000000,
        S_MRA  = 13'b0010000000000,
        S_MRB  = 13'b0100000000000,
        S_DONE = 13'b1000000000000
    } state_t;

    function automatic logic signed [POS_WIDTH-1:0] clamp_pos(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        r = v;
        if (v > PMAX)
        begin
            r = PMAX;
        end
        else if (v < PMIN)
        begin
            r = PMIN;
        end
        return r[POS_WIDTH-1:0];
    endfunction

    function automatic logic [31:0] clamp_32(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        r = v;
        if (v > I32MAX)
        begin
            r = I32MAX;
        end
        else if (v < I32MIN)
        begin
            r = I32MIN;
        end
        return r[31:0];
    endfunction

    state_t state_reg, state_next;

    logic signed [31:0] start_x_reg, start_x_next;
    logic signed [31:0] start_y_reg, start_y_next;
    logic signed [15:0] start_yaw_reg, start_yaw_next;
    logic               bicycle_reg, bicycle_next;
    logic [15:0]        slip_reg, slip_next;
    logic [15:0]        inv_rear_reg, inv_rear_next;

    logic signed [POS_WIDTH-1:0] pos_x_reg, pos_x_next;
    logic signed [POS_WIDTH-1:0] pos_y_reg, pos_y_next;
    logic signed [15:0]          heading_reg, heading_next;
    logic signed [15:0]          ref_yaw_reg, ref_yaw_next;
    logic                        ref_taken_reg, ref_taken_next;

    logic signed [15:0]   speed_reg, speed_next;
    logic [EL_W-1:0]      el_reg, el_next;
    angle_t               beta_reg, beta_next;
    logic signed [15:0]   yr_reg, yr_next;

    logic signed [MW-1:0] ma_reg, ma_next;
    logic [MB-1:0]        mb_reg, mb_next;
    logic signed [MW-1:0] acc_reg, acc_next;
    logic [MCNT_W-1:0]    mcnt_reg, mcnt_next;

    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    cordic_req_t cq;
    cordic_rsp_t crsp;
    vec_t        c_x_in;
    vec_t        c_y_in;
    angle_t      c_z_in;
    vec_t        c_x_out;
    vec_t        c_y_out;
    angle_t      c_z_out;

    logic                  s_fire;
    logic signed [15:0]    in_speed;
    logic signed [14:0]    in_steer;
    logic signed [15:0]    in_yaw;
    logic [EL_W-1:0]       in_el;
    logic                  el_ok;
    logic                  reload;
    logic                  mul_state;
    logic                  mul_busy;
    logic                  mul_start;
    logic signed [MW-1:0]  mul_a;
    logic [MB-1:0]         mul_b;
    logic signed [MW-1:0]  acc_sh14;
    vec_t                  num;
    angle_t                hd_ang;
    logic signed [CW-1:0]  dstep;
    logic signed [MW-1:0]  yr_full;
    logic signed [HD_W-1:0] hd_diff;
    logic signed [HD_W-1:0] hd_wrap;
    logic signed [31:0]    ns_x;
    logic signed [31:0]    ns_y;
    logic signed [15:0]    ns_yaw;

    assign in_speed = s_axis_tdata[15:0];
    assign in_steer = s_axis_tdata[30:16];
    assign in_yaw   = s_axis_tdata[46:31];
    assign in_el    = s_axis_tdata[67:47];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_fire        = s_axis_tvalid & s_axis_tready;
    assign el_ok         = (in_el >= EL_MIN) && (in_el <= EL_MAX);
    assign reload        = cfg_we && (cfg_index <= REG_INV_REAR);

    assign mul_state = (state_reg == S_MN) || (state_reg == S_MXA) || (state_reg == S_MXB) ||
                       (state_reg == S_MYA) || (state_reg == S_MYB) ||
                       (state_reg == S_MRA) || (state_reg == S_MRB);
    assign mul_busy  = (mcnt_reg != MB_DONE);
    assign acc_sh14  = acc_reg >>> 14;
    assign num       = XW'(acc_reg >>> 16);
    assign hd_ang    = AW'(heading_reg) <<< 15;
    assign dstep     = CW'((acc_reg + RND_POS) >>> 30);
    assign yr_full   = (acc_reg + RND_YR) >>> 24;

    // yaw relative to the latched reference, wrapped once
    always_comb
    begin
        hd_diff = HD_W'(in_yaw) - HD_W'(ref_yaw_reg) + HD_W'(start_yaw_reg);
        hd_wrap = hd_diff;
        if (hd_diff > WRAP_LIMIT)
        begin
            hd_wrap = hd_diff - WRAP_STEP;
        end
        else if (hd_diff < -WRAP_LIMIT)
        begin
            hd_wrap = hd_diff + WRAP_STEP;
        end
    end

    always_comb
    begin
        ns_x   = (cfg_index == REG_START_X) ? cfg_data : start_x_reg;
        ns_y   = (cfg_index == REG_START_Y) ? cfg_data : start_y_reg;
        ns_yaw = (cfg_index == REG_START_YAW) ? cfg_data[15:0] : start_yaw_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        start_x_next   = start_x_reg;
        start_y_next   = start_y_reg;
        start_yaw_next = start_yaw_reg;
        bicycle_next   = bicycle_reg;
        slip_next      = slip_reg;
        inv_rear_next  = inv_rear_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        heading_next   = heading_reg;
        ref_yaw_next   = ref_yaw_reg;
        ref_taken_next = ref_taken_reg;
        speed_next     = speed_reg;
        el_next        = el_reg;
        beta_next      = beta_reg;
        yr_next        = yr_reg;
        ma_next        = ma_reg;
        mb_next        = mb_reg;
        acc_next       = acc_reg;
        mcnt_next      = mcnt_reg;
        out_valid_next = out_valid_reg & ~m_axis_tready;
        out_data_next  = out_data_reg;
        cq             = '0;
        c_x_in         = '0;
        c_y_in         = '0;
        c_z_in         = '0;
        mul_start      = 1'b0;
        mul_a          = '0;
        mul_b          = '0;

        // shift-add step, sign bit of the multiplier weighs negative
        if (mul_state && mul_busy)
        begin
            if (mb_reg[0])
            begin
                acc_next = (mcnt_reg == MB_LAST) ? (acc_reg - ma_reg) : (acc_reg + ma_reg);
            end
            ma_next   = ma_reg <<< 1;
            mb_next   = mb_reg >> 1;
            mcnt_next = mcnt_reg + 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_fire && el_ok)
                begin
                    speed_next = in_speed;
                    el_next    = in_el;
                    cq.start   = 1'b1;
                    c_z_in     = AW'(in_steer) <<< 15;
                    state_next = S_SC1;
                end
            end
            S_SC1:
            begin
                if (crsp.done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = MW'(c_y_out);
                    mul_b      = MB'(slip_reg);
                    state_next = S_MN;
                end
            end
            S_MN:
            begin
                if (!mul_busy)
                begin
                    if ((c_x_out == '0) && (num == '0))
                    begin
                        beta_next  = '0;
                        cq.start   = 1'b1;
                        c_z_in     = hd_ang;
                        state_next = S_SC2;
                    end
                    else
                    begin
                        cq.start   = 1'b1;
                        cq.vector  = 1'b1;
                        c_x_in     = c_x_out[XW-1] ? -c_x_out : c_x_out;
                        c_y_in     = c_x_out[XW-1] ? -num : num;
                        state_next = S_VEC;
                    end
                end
            end
            S_VEC:
            begin
                if (crsp.done)
                begin
                    beta_next  = c_z_out;
                    cq.start   = 1'b1;
                    c_z_in     = bicycle_reg ? (hd_ang + c_z_out) : hd_ang;
                    state_next = S_SC2;
                end
            end
            S_SC2:
            begin
                if (crsp.done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = MW'(c_x_out);
                    mul_b      = MB'(speed_reg);
                    state_next = S_MXA;
                end
            end
            S_MXA:
            begin
                if (!mul_busy)
                begin
                    mul_start  = 1'b1;
                    mul_a      = acc_sh14;
                    mul_b      = MB'(el_reg);
                    state_next = S_MXB;
                end
            end
            S_MXB:
            begin
                if (!mul_busy)
                begin
                    pos_x_next = clamp_pos(CW'(pos_x_reg) + dstep);
                    mul_start  = 1'b1;
                    mul_a      = MW'(c_y_out);
                    mul_b      = MB'(speed_reg);
                    state_next = S_MYA;
                end
            end
            S_MYA:
            begin
                if (!mul_busy)
                begin
                    mul_start  = 1'b1;
                    mul_a      = acc_sh14;
                    mul_b      = MB'(el_reg);
                    state_next = S_MYB;
                end
            end
            S_MYB:
            begin
                if (!mul_busy)
                begin
                    pos_y_next = clamp_pos(CW'(pos_y_reg) + dstep);
                    cq.start   = 1'b1;
                    c_z_in     = beta_reg;
                    state_next = S_SC3;
                end
            end
            S_SC3:
            begin
                if (crsp.done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = MW'(c_y_out);
                    mul_b      = MB'(speed_reg);
                    state_next = S_MRA;
                end
            end
            S_MRA:
            begin
                if (!mul_busy)
                begin
                    mul_start  = 1'b1;
                    mul_a      = acc_sh14;
                    mul_b      = MB'(inv_rear_reg);
                    state_next = S_MRB;
                end
            end
            S_MRB:
            begin
                if (!mul_busy)
                begin
                    if (yr_full > YR_MAX)
                    begin
                        yr_next = 16'sh7fff;
                    end
                    else if (yr_full < YR_MIN)
                    begin
                        yr_next = 16'sh8000;
                    end
                    else
                    begin
                        yr_next = yr_full[15:0];
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {yr_reg, speed_reg, heading_reg,
                                      clamp_32(CW'(pos_y_reg)), clamp_32(CW'(pos_x_reg))};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (mul_start)
        begin
            ma_next   = mul_a;
            mb_next   = mul_b;
            acc_next  = '0;
            mcnt_next = '0;
        end

        if (reload)
        begin
            case (cfg_index)
                REG_START_X:   start_x_next   = cfg_data;
                REG_START_Y:   start_y_next   = cfg_data;
                REG_START_YAW: start_yaw_next = cfg_data[15:0];
                REG_BICYCLE:   bicycle_next   = cfg_data[0];
                REG_SLIP:      slip_next      = cfg_data[15:0];
                REG_INV_REAR:  inv_rear_next  = cfg_data[15:0];
                default:       start_x_next   = start_x_reg;
            endcase
            pos_x_next     = clamp_pos(CW'(ns_x));
            pos_y_next     = clamp_pos(CW'(ns_y));
            heading_next   = ns_yaw;
            ref_yaw_next   = '0;
            ref_taken_next = 1'b0;
        end
        else if (s_fire && s_axis_tuser)
        begin
            if (!ref_taken_reg)
            begin
                ref_taken_next = 1'b1;
                ref_yaw_next   = in_yaw;
                heading_next   = start_yaw_reg;
            end
            else if (hd_wrap > HD_MAX)
            begin
                heading_next = 16'sh7fff;
            end
            else if (hd_wrap < HD_MIN)
            begin
                heading_next = 16'sh8000;
            end
            else
            begin
                heading_next = hd_wrap[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_x_reg   <= START_X_RST;
            start_y_reg   <= START_Y_RST;
            start_yaw_reg <= START_YAW_RST;
            bicycle_reg   <= BICYCLE_RST;
            slip_reg      <= SLIP_RST;
            inv_rear_reg  <= INV_REAR_RST;
            pos_x_reg     <= POS_X_RST;
            pos_y_reg     <= POS_Y_RST;
            heading_reg   <= START_YAW_RST;
            ref_yaw_reg   <= '0;
            ref_taken_reg <= 1'b0;
            mcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_x_reg   <= start_x_next;
            start_y_reg   <= start_y_next;
            start_yaw_reg <= start_yaw_next;
            bicycle_reg   <= bicycle_next;
            slip_reg      <= slip_next;
            inv_rear_reg  <= inv_rear_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            heading_reg   <= heading_next;
            ref_yaw_reg   <= ref_yaw_next;
            ref_taken_reg <= ref_taken_next;
            mcnt_reg      <= mcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        speed_reg    <= speed_next;
        el_reg       <= el_next;
        beta_reg     <= beta_next;
        yr_reg       <= yr_next;
        ma_reg       <= ma_next;
        mb_reg       <= mb_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    bmo_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cq),
        .x_in  (c_x_in),
        .y_in  (c_y_in),
        .z_in  (c_z_in),
        .rsp   (crsp),
        .x_out (c_x_out),
        .y_out (c_y_out),
        .z_out (c_z_out)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

>>> rtl/bmo_checker.sv
// ----------------------------------------------------------------------------
// bmo_checker
// Port-level checks of the bicycle model odometry unit, bound to the top level.
// ----------------------------------------------------------------------------
module bmo_checker
    import bmo_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

    // a tick in range keeps the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready &&
        (s_axis_tdata[67:47] >= EL_MIN) && (s_axis_tdata[67:47] <= EL_MAX)
        |=> !s_axis_tready)
    else $error("request in range not held busy");

    // a tick out of range gives no result and frees the input at once
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready &&
        ((s_axis_tdata[67:47] < EL_MIN) || (s_axis_tdata[67:47] > EL_MAX))
        |=> s_axis_tready && !$rose(m_axis_tvalid))
    else $error("rejected request not dropped");

    // a new result only follows a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result without a request in progress");

endmodule

bind bicycle_model_odometry_unit bmo_checker u_bmo_checker (.*);

>>> bench/tb_bicycle_model_odometry_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bicycle_model_odometry_unit
// Drives odometry ticks into the unit under several register settings, with
// random gaps on both streams, and checks every pose result against an
// independent fixed-point dead-reckoning model kept inside the bench.
// ----------------------------------------------------------------------------
module tb_bicycle_model_odometry_unit;
    import bmo_pkg::*;

    localparam int STEPS      = 16;
    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE     = 400;
    localparam longint unsigned ONE60 = 64'd1 << 60;

    typedef struct {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading;
        logic signed [15:0] speed_out;
        logic signed [15:0] yaw_rate;
    } pose_t;

    typedef struct {
        int   speed;
        int   steer;
        int   yaw;
        bit   yaw_ok;
        int   elapsed;
        bit   typed;
        pose_t want;
    } tick_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = REG_START_X;
    logic [31:0]            cfg_data = '0;

    bicycle_model_odometry_unit dut (.*);

    always #1 clk = ~clk;

    // model state
    longint atan_q [TAB_LEN];
    longint pi_val, gain_val;
    longint odo_x, odo_y;
    int     odo_heading, odo_ref_yaw;
    bit     odo_ref_taken;
    int     r_start_x, r_start_y, r_start_yaw, r_bicycle, r_slip, r_inv_rear;

    pose_t  pending_poses [$];
    int     errors, ticks_sent, poses_seen, idle_cycles;
    bit     rx_quiet, tx_quiet;
    int     stall_left;

    function automatic longint unsigned atan_recip(longint unsigned n);
        longint unsigned p, sum, n2, k, term;
        p = ONE60 / n;
        sum = 0;
        n2 = n * n;
        k = 0;
        while (p != 0)
        begin
            term = p / (2 * k + 1);
            if (k[0]) sum -= term;
            else sum += term;
            p /= n2;
            k++;
        end
        return sum;
    endfunction

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic void build_angle_tables();
        longint unsigned pi4, p, a;
        pi4 = 4 * atan_recip(5) - atan_recip(239);
        atan_q[0] = longint'((pi4 + (64'd1 << 31)) >> 32);
        for (int i = 1; i < TAB_LEN; i++)
            atan_q[i] = longint'((atan_recip(64'd1 << i) + (64'd1 << 31)) >> 32);
        pi_val = longint'((4 * pi4 + (64'd1 << 31)) >> 32);
        p = ONE60;
        for (int i = 0; i < STEPS; i++)
            p += p >> (2 * i);
        a = isqrt(p);
        gain_val = longint'((ONE60 + a / 2) / a);
    endfunction

    function automatic longint clamp(longint v, int w);
        longint hi;
        hi = (64'sd1 <<< (w - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic void rotate(longint a, output longint c, output longint s);
        longint x, y, t;
        bit flip;
        x = gain_val;
        y = 0;
        flip = 1'b0;
        while (a > pi_val) a -= 2 * pi_val;
        while (a < -pi_val) a += 2 * pi_val;
        if (a > pi_val / 2)
        begin
            a -= pi_val;
            flip = 1'b1;
        end
        else if (a < -(pi_val / 2))
        begin
            a += pi_val;
            flip = 1'b1;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            if (a >= 0)
            begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                a -= atan_q[i];
            end
            else
            begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                a += atan_q[i];
            end
            x = t;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint slip_angle(longint x, longint y);
        longint z, t;
        z = 0;
        if (x == 0 && y == 0) return 0;
        for (int i = 0; i < STEPS; i++)
        begin
            if (y < 0)
            begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z -= atan_q[i];
            end
            else
            begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z += atan_q[i];
            end
            x = t;
        end
        return z;
    endfunction

    function automatic void reload_pose();
        odo_x = r_start_x;
        odo_y = r_start_y;
        odo_heading = r_start_yaw;
        odo_ref_yaw = 0;
        odo_ref_taken = 1'b0;
    endfunction

    // advances the dead-reckoning state by one tick
    function automatic bit advance_pose(int speed, int steer, int yaw, bit yaw_ok,
                                        int elapsed, output pose_t p);
        longint sc, ss, num, den, beta, hc, hs, bc, bs, dx, dy, yr, d;
        if (yaw_ok)
        begin
            if (!odo_ref_taken)
            begin
                odo_ref_taken = 1'b1;
                odo_ref_yaw = yaw;
                odo_heading = r_start_yaw;
            end
            else
            begin
                d = longint'(yaw) - odo_ref_yaw + r_start_yaw;
                if (d > WRAP_LIMIT) d -= WRAP_STEP;
                else if (d < -WRAP_LIMIT) d += WRAP_STEP;
                odo_heading = int'(clamp(d, 16));
            end
        end
        if (elapsed < EL_MIN || elapsed > EL_MAX) return 1'b0;
        rotate(longint'(steer) * 32768, sc, ss);
        num = (ss * r_slip) >>> 16;
        den = sc;
        if (den < 0)
        begin
            num = -num;
            den = -den;
        end
        beta = slip_angle(den, num);
        rotate(longint'(odo_heading) * 32768 + (r_bicycle ? beta : 0), hc, hs);
        dx = (((speed * hc) >>> 14) * elapsed + (64'sd1 <<< 29)) >>> 30;
        dy = (((speed * hs) >>> 14) * elapsed + (64'sd1 <<< 29)) >>> 30;
        odo_x = clamp(odo_x + dx, 32);
        odo_y = clamp(odo_y + dy, 32);
        rotate(beta, bc, bs);
        yr = (((speed * bs) >>> 14) * r_inv_rear + (64'sd1 <<< 23)) >>> 24;
        p.pos_x = 32'(odo_x);
        p.pos_y = 32'(odo_y);
        p.heading = 16'(odo_heading);
        p.speed_out = 16'(speed);
        p.yaw_rate = 16'(clamp(yr, 16));
        return 1'b1;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        errors++;
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 poses_seen, field, got, want);
    endtask

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            pose_t got, want;
            got.pos_x = m_axis_tdata[31:0];
            got.pos_y = m_axis_tdata[63:32];
            got.heading = m_axis_tdata[79:64];
            got.speed_out = m_axis_tdata[95:80];
            got.yaw_rate = m_axis_tdata[111:96];
            poses_seen++;
            if (pending_poses.size() == 0)
            begin
                errors++;
                $display("unexpected result %0d", poses_seen);
            end
            else
            begin
                want = pending_poses.pop_front();
                if (got.pos_x !== want.pos_x) report_mismatch("pos_x", got.pos_x, want.pos_x);
                if (got.pos_y !== want.pos_y) report_mismatch("pos_y", got.pos_y, want.pos_y);
                if (got.heading !== want.heading)
                    report_mismatch("heading", got.heading, want.heading);
                if (got.speed_out !== want.speed_out)
                    report_mismatch("speed_out", got.speed_out, want.speed_out);
                if (got.yaw_rate !== want.yaw_rate)
                    report_mismatch("yaw_rate", got.yaw_rate, want.yaw_rate);
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        if (!rst_n) m_axis_tready <= 1'b0;
        else if (rx_quiet) m_axis_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 9) < 3)
                stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 150)
                                                            : $urandom_range(1, 4);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        case (idx)
            REG_START_X:   r_start_x = int'(value);
            REG_START_Y:   r_start_y = int'(value);
            REG_START_YAW: r_start_yaw = int'(signed'(value[15:0]));
            REG_BICYCLE:   r_bicycle = value[0];
            REG_SLIP:      r_slip = value[15:0];
            REG_INV_REAR:  r_inv_rear = value[15:0];
            default: ;
        endcase
        reload_pose();
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // hold-off until the unit is idle
    task automatic drain();
        while (pending_poses.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_tick(int speed, int steer, int yaw, bit yaw_ok, int elapsed,
                             bit typed, pose_t want);
        pose_t p;
        int    gap;
        if (!tx_quiet)
        begin
            gap = $urandom_range(0, 19);
            gap = (gap < 13) ? 0 : (gap < 19) ? $urandom_range(1, 4) : $urandom_range(20, 120);
            if (gap > 0)
            begin
                @(negedge clk);
                s_axis_tvalid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {4'd0, 21'(elapsed), 16'(yaw), 15'(steer), 16'(speed)};
        s_axis_tuser = yaw_ok;
        do @(posedge clk); while (!s_axis_tready);
        ticks_sent++;
        if (advance_pose(speed, steer, yaw, yaw_ok, elapsed, p))
            pending_poses.push_back(typed ? want : p);
    endtask

    task automatic send_random_tick();
        int elapsed, speed, steer;
        pose_t none;
        none = '{default: 0};
        case ($urandom_range(0, 19))
            0:       elapsed = $urandom_range(0, EL_MIN - 1);
            1:       elapsed = $urandom_range(EL_MAX + 1, 2097151);
            2:       elapsed = $urandom_range(0, 1) ? EL_MIN : EL_MAX;
            default: elapsed = $urandom_range(EL_MIN, EL_MAX);
        endcase
        speed = $urandom_range(0, 65535) - 32768;
        steer = $urandom_range(0, 32767) - 16384;
        send_tick(speed, steer, $urandom_range(0, 51472) - 25736, $urandom_range(0, 3) != 0,
                  elapsed, 1'b0, none);
    endtask

    tick_row_t directed [] = '{
        '{0, 0, 0, 1, 10000, 1, '{32'sd163840, 32'sd32768, 16'sd0, 16'sd0, 16'sd0}},
        '{1000, 100, 4000, 1, EL_MIN - 1, 0, '{default: 0}},
        '{1000, 100, 4000, 1, EL_MAX + 1, 0, '{default: 0}},
        '{0, 0, 0, 1, 0, 0, '{default: 0}},
        '{0, 0, 0, 1, 2097151, 0, '{default: 0}},
        '{32767, 0, 8192, 1, EL_MIN, 0, '{default: 0}},
        '{-32768, 0, -8192, 1, EL_MAX, 0, '{default: 0}},
        '{32767, 16383, 25736, 1, 500000, 0, '{default: 0}},
        '{32767, -16384, -25736, 1, 500000, 0, '{default: 0}},
        '{-32768, -16384, 25736, 0, EL_MAX, 0, '{default: 0}},
        '{20000, 3000, 12000, 1, 100000, 0, '{default: 0}},
        '{20000, -3000, -12000, 1, 100000, 0, '{default: 0}},
        '{-1, 1, 1, 1, 1048575, 0, '{default: 0}},
        '{12345, -12345, -1, 0, 777777, 0, '{default: 0}},
        '{-21846, 10922, 21845, 1, 349525, 0, '{default: 0}},
        '{21845, -10923, -21846, 1, 699050, 0, '{default: 0}}
    };

    initial
    begin
        errors = 0;
        ticks_sent = 0;
        poses_seen = 0;
        idle_cycles = 0;
        stall_left = 0;
        rx_quiet = 1'b0;
        tx_quiet = 1'b0;
        build_angle_tables();
        r_start_x = START_X_RST;
        r_start_y = START_Y_RST;
        r_start_yaw = START_YAW_RST;
        r_bicycle = BICYCLE_RST;
        r_slip = SLIP_RST;
        r_inv_rear = INV_REAR_RST;
        reload_pose();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
            send_tick(directed[i].speed, directed[i].steer, directed[i].yaw,
                      directed[i].yaw_ok, directed[i].elapsed, directed[i].typed,
                      directed[i].want);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        drain();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                1:
                begin
                    write_reg(REG_START_X, 32'h7fff_ff00);
                    write_reg(REG_START_Y, 32'h8000_0100);
                    write_reg(REG_START_YAW, 32'(25736));
                    write_reg(REG_BICYCLE, 32'd1);
                    write_reg(REG_SLIP, 32'd65535);
                    write_reg(REG_INV_REAR, 32'd65535);
                end
                2:
                begin
                    write_reg(REG_START_YAW, 32'(-25736));
                    write_reg(REG_SLIP, 32'd0);
                    write_reg(REG_INV_REAR, 32'd0);
                    write_reg(REG_BICYCLE, 32'd0);
                    write_reg(REG_START_X, 32'h8000_0000);
                    write_reg(REG_START_Y, 32'h7fff_ffff);
                end
                3, 4:
                begin
                    write_reg(REG_START_X, $urandom);
                    write_reg(REG_START_Y, $urandom);
                    write_reg(REG_START_YAW, 32'($urandom_range(0, 51472) - 25736));
                    write_reg(REG_BICYCLE, 32'(phase == 3));
                    write_reg(REG_SLIP, $urandom_range(0, 65535));
                    write_reg(REG_INV_REAR, $urandom_range(0, 65535));
                end
                default: ;
            endcase
            rx_quiet = (phase == 2);
            tx_quiet = (phase == 2);
            for (int n = 0; n < 146; n++)
                send_random_tick();
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            drain();
        end

        $display("%0d ticks sent, %0d pose results checked over five register settings",
                 ticks_sent, poses_seen);
        $display("covered extreme start poses, slip and rear-length values, and both modes");
        if (errors == 0 && pending_poses.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
